FILE: rtl/core/rd64_pkg.sv
// ----------------------------------------------------------------------------
// rd64_pkg: shared types and constants of the 64-bit restoring divider
// Item payload structs, the operation codes and the per-item sign and
// divide-by-zero flags that travel down the cell chain.
// ----------------------------------------------------------------------------
package rd64_pkg;

   localparam int DATA_WIDTH_DEF = 64;
   localparam int PORT_WIDTH     = 64;

   typedef enum logic [1:0] {
      OP_DIV  = 2'd0,
      OP_REM  = 2'd1,
      OP_DIVU = 2'd2,
      OP_REMU = 2'd3
   } rd64_op_type;

   typedef struct packed {
      rd64_op_type             opcode;
      logic [PORT_WIDTH-1:0]   dividend;
      logic [PORT_WIDTH-1:0]   divisor;
   } rd64_req_type;

   typedef struct packed {
      logic [PORT_WIDTH-1:0]   answer;
      logic                    divide_by_zero;
   } rd64_rsp_type;

   // Per-item control carried alongside the partial remainder.
   typedef struct packed {
      logic want_rem;
      logic neg_q;
      logic neg_r;
      logic div_zero;
   } rd64_flags_type;

endpackage

FILE: rtl/core/rd64_prep.sv
// ----------------------------------------------------------------------------
// rd64_prep: operand preparation stage
// Decodes the operation, takes the operand magnitudes for signed work,
// detects a zero divisor and registers the result for the first cell.
// ----------------------------------------------------------------------------
module rd64_prep
   import rd64_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rd64_req_type          in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] out_n,
   output logic [DATA_WIDTH-1:0] out_d,
   output rd64_flags_type        out_flags
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [DATA_WIDTH-1:0] n_ff;
   logic [DATA_WIDTH-1:0] n_in;
   logic [DATA_WIDTH-1:0] d_ff;
   logic [DATA_WIDTH-1:0] d_in;
   rd64_flags_type        flags_ff;
   rd64_flags_type        flags_in;
   logic [DATA_WIDTH-1:0] a;
   logic [DATA_WIDTH-1:0] b;
   logic                  is_signed;
   logic                  want_rem;
   logic                  neg_a;
   logic                  neg_b;
   logic                  load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      unique case (in_data.opcode)
         OP_DIV: begin
            is_signed = 1'b1;
            want_rem  = 1'b0;
         end
         OP_REM: begin
            is_signed = 1'b1;
            want_rem  = 1'b1;
         end
         OP_DIVU: begin
            is_signed = 1'b0;
            want_rem  = 1'b0;
         end
         OP_REMU: begin
            is_signed = 1'b0;
            want_rem  = 1'b1;
         end
         default: begin
            is_signed = 1'b0;
            want_rem  = 1'b0;
         end
      endcase
   end

   always_comb begin
      a     = in_data.dividend[DATA_WIDTH-1:0];
      b     = in_data.divisor[DATA_WIDTH-1:0];
      neg_a = is_signed && a[DATA_WIDTH-1];
      neg_b = is_signed && b[DATA_WIDTH-1];
      // The most negative value negates to itself, which reads as 2^(W-1).
      n_in  = neg_a ? ({DATA_WIDTH{1'b0}} - a) : a;
      d_in  = neg_b ? ({DATA_WIDTH{1'b0}} - b) : b;
      flags_in.want_rem = want_rem;
      flags_in.neg_q    = neg_a ^ neg_b;
      flags_in.neg_r    = neg_a;
      flags_in.div_zero = (b == {DATA_WIDTH{1'b0}});
      valid_in = load || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         n_ff     <= n_in;
         d_ff     <= d_in;
         flags_ff <= flags_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_n     = n_ff;
   assign out_d     = d_ff;
   assign out_flags = flags_ff;

endmodule

FILE: rtl/core/rd64_cell.sv
// ----------------------------------------------------------------------------
// rd64_cell: one restoring division step
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit into the low end of the
// dividend register, then hands the item to the next cell.
// ----------------------------------------------------------------------------
module rd64_cell
   import rd64_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DATA_WIDTH-1:0] in_r,
   input  logic [DATA_WIDTH-1:0] in_nq,
   input  logic [DATA_WIDTH-1:0] in_d,
   input  rd64_flags_type        in_flags,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] out_r,
   output logic [DATA_WIDTH-1:0] out_nq,
   output logic [DATA_WIDTH-1:0] out_d,
   output rd64_flags_type        out_flags
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [DATA_WIDTH-1:0] r_ff;
   logic [DATA_WIDTH-1:0] r_in;
   logic [DATA_WIDTH-1:0] nq_ff;
   logic [DATA_WIDTH-1:0] nq_in;
   logic [DATA_WIDTH-1:0] d_ff;
   rd64_flags_type        flags_ff;
   logic [DATA_WIDTH-1:0] shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  take;
   logic                  load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      shifted = {in_r[DATA_WIDTH-2:0], in_nq[DATA_WIDTH-1]};
      diff    = {1'b0, shifted} - {1'b0, in_d};
      // The bit shifted out of the remainder counts as 2^W, so it always fits.
      take    = in_r[DATA_WIDTH-1] || !diff[DATA_WIDTH];
      r_in    = take ? diff[DATA_WIDTH-1:0] : shifted;
      nq_in   = {in_nq[DATA_WIDTH-2:0], take};
      valid_in = load || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         r_ff     <= r_in;
         nq_ff    <= nq_in;
         d_ff     <= in_d;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_r     = r_ff;
   assign out_nq    = nq_ff;
   assign out_d     = d_ff;
   assign out_flags = flags_ff;

endmodule

FILE: rtl/core/rd64_post.sv
// ----------------------------------------------------------------------------
// rd64_post: result selection and output register
// Picks quotient or remainder, applies the result sign, forces zero on a
// zero divisor and holds the finished item for the result channel.
// ----------------------------------------------------------------------------
module rd64_post
   import rd64_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DATA_WIDTH-1:0] in_r,
   input  logic [DATA_WIDTH-1:0] in_q,
   input  rd64_flags_type        in_flags,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rd64_rsp_type          out_data
);

   logic                  valid_ff;
   logic                  valid_in;
   rd64_rsp_type          data_ff;
   rd64_rsp_type          data_in;
   logic [DATA_WIDTH-1:0] sel;
   logic                  neg;
   logic [DATA_WIDTH-1:0] res;
   logic                  load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      sel = in_flags.want_rem ? in_r : in_q;
      neg = in_flags.want_rem ? in_flags.neg_r : in_flags.neg_q;
      res = neg ? ({DATA_WIDTH{1'b0}} - sel) : sel;
      if (in_flags.div_zero) begin
         res = {DATA_WIDTH{1'b0}};
      end
      data_in.answer         = PORT_WIDTH'(res);
      data_in.divide_by_zero = in_flags.div_zero;
      valid_in = load || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/core/restoring_divider_64.sv
// Pipeline: one operand stage, one cell per quotient bit, one output stage.
// Throughput: one item per cycle while results are taken; each cell stage holds one item in flight.
// A stalled result only stops the stages behind it that are full.
// Reset is synchronous and active high; it empties every stage, no clearing pass.
// ----------------------------------------------------------------------------
// restoring_divider_64: pipelined signed/unsigned restoring divider
// A chain of identical cells, one per quotient bit, divides the operand
// magnitudes; prep and post stages handle signs and the zero divisor.
// ----------------------------------------------------------------------------
module restoring_divider_64
   import rd64_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  rd64_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rd64_rsp_type rsp_data
);

   // Index 0 is the prep stage output; index k+1 is the output of cell k.
   logic                  chain_valid [DATA_WIDTH+1];
   logic                  chain_ready [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] chain_r     [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] chain_nq    [DATA_WIDTH+1];
   logic [DATA_WIDTH-1:0] chain_d     [DATA_WIDTH+1];
   rd64_flags_type        chain_flags [DATA_WIDTH+1];

   rd64_prep #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_n     (chain_nq[0]),
      .out_d     (chain_d[0]),
      .out_flags (chain_flags[0])
   );

   // The partial remainder starts at zero.
   assign chain_r[0] = {DATA_WIDTH{1'b0}};

   for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
      rd64_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_r      (chain_r[k]),
         .in_nq     (chain_nq[k]),
         .in_d      (chain_d[k]),
         .in_flags  (chain_flags[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_r     (chain_r[k+1]),
         .out_nq    (chain_nq[k+1]),
         .out_d     (chain_d[k+1]),
         .out_flags (chain_flags[k+1])
      );
   end

   rd64_post #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[DATA_WIDTH]),
      .in_ready  (chain_ready[DATA_WIDTH]),
      .in_r      (chain_r[DATA_WIDTH]),
      .in_q      (chain_nq[DATA_WIDTH]),
      .in_flags  (chain_flags[DATA_WIDTH]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // A zero divisor always yields a zero answer.
   a_zero_div_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |-> rsp_data.answer == '0)
      else $error("divide by zero item carries a nonzero answer");

   // Bits above the configured width are never set.
   a_upper_bits_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.answer >> DATA_WIDTH) == '0)
      else $error("answer has bits set above DATA_WIDTH");

   // The input side only stalls when the whole chain backs up from the output.
   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while the result channel is free");

   // Reset empties the output stage.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item present right after reset");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for restoring_divider_64
// Drives signed and unsigned divide and remainder items through the
// valid/ready channels under varying back-pressure. A scoreboard predicts
// every result and compares it with what the divider returns.
// ----------------------------------------------------------------------------
module testbench;
   import rd64_pkg::*;

   localparam int   HALF_PERIOD    = 4;
   localparam int   RESET_CYCLES   = 10;
   localparam int   RANDOM_PER_RUN = 650;
   localparam int   DRAIN_CYCLES   = 80;
   localparam int   HOLD_CYCLES    = 400;
   localparam int   WATCHDOG_LIMIT = 5000;
   localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   rd64_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rd64_rsp_type rsp_data;

   restoring_divider_64 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   class divide_scoreboard;
      rd64_rsp_type expected_answers[$];
      int           mismatches;
      int           checked;
      int           zero_divisor_seen;
      int           op_count[4];

      // Bit-serial restoring division on the operand magnitudes.
      function rd64_rsp_type predict(rd64_req_type item);
         logic [63:0]  num;
         logic [63:0]  den;
         logic [63:0]  quo;
         logic [63:0]  rmd;
         logic         carry;
         logic         neg_n;
         logic         neg_d;
         logic         want_rem;
         logic         signed_op;
         int           i;
         rd64_rsp_type res;
         want_rem  = (item.opcode == OP_REM) || (item.opcode == OP_REMU);
         signed_op = (item.opcode == OP_DIV) || (item.opcode == OP_REM);
         num = item.dividend;
         den = item.divisor;
         res.answer         = '0;
         res.divide_by_zero = 1'b0;
         if (den == '0) begin
            res.divide_by_zero = 1'b1;
            return res;
         end
         neg_n = signed_op && num[63];
         neg_d = signed_op && den[63];
         if (neg_n) num = -num;
         if (neg_d) den = -den;
         quo = '0;
         rmd = '0;
         for (i = 63; i >= 0; i--) begin
            // The bit shifted out keeps divisors with the top bit set correct.
            carry = rmd[63];
            rmd   = {rmd[62:0], num[i]};
            if (carry || rmd >= den) begin
               rmd    = rmd - den;
               quo[i] = 1'b1;
            end
         end
         if (neg_n != neg_d) quo = -quo;
         if (neg_n) rmd = -rmd;
         res.answer = want_rem ? rmd : quo;
         return res;
      endfunction

      function void note_request(rd64_req_type item);
         expected_answers.push_back(predict(item));
         op_count[item.opcode]++;
      endfunction

      function void report_mismatch(string what, logic [63:0] exp_val, logic [63:0] act_val);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", what, exp_val, act_val);
      endfunction

      function void check_response(rd64_rsp_type got);
         rd64_rsp_type want;
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result with no item outstanding: answer %h flag %b",
                        got.answer, got.divide_by_zero);
            return;
         end
         want = expected_answers.pop_front();
         checked++;
         if (got.divide_by_zero) zero_divisor_seen++;
         if (got.answer !== want.answer)
            report_mismatch("answer", want.answer, got.answer);
         if (got.divide_by_zero !== want.divide_by_zero)
            report_mismatch("divide_by_zero", 64'(want.divide_by_zero),
                            64'(got.divide_by_zero));
      endfunction

      function int pending();
         return expected_answers.size();
      endfunction
   endclass

   divide_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles;
   int hold_threshold;
   bit hold_done;

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   function automatic logic [63:0] pick_operand();
      logic [63:0] v;
      case ($urandom_range(9))
         0: v = '0;
         1: v = ALL_ONES;
         2: v = MOST_NEG;
         3: v = MOST_POS;
         4: v = 64'($urandom_range(15));
         5: v = -64'($urandom_range(15));
         6: v = {$urandom, $urandom} >> $urandom_range(63);
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input rd64_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      rd64_req_type item;
      repeat (count) begin
         item.opcode   = rd64_op_type'($urandom_range(3));
         item.dividend = pick_operand();
         item.divisor  = pick_operand();
         send_item(item);
      end
   endtask

   // Receiver: random back-pressure, plus one long hold once the last
   // phase is under way so the pipeline fills and stalls its input.
   initial begin
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && sb.checked >= hold_threshold) begin
            hold_done = 1'b1;
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                        quiet_cycles, sb.pending());
               $display("testbench: FAIL");
               $finish;
            end
         end
      end
   end

   initial begin
      logic [63:0]  dir_dividend[6];
      logic [63:0]  dir_divisor[6];
      rd64_op_type  all_ops[4];
      rd64_req_type item;
      int           p;
      int           k;
      sb = new();
      quiet_cycles  = 0;
      req_valid     = 1'b0;
      req_data      = '0;
      reset         = 1'b1;
      send_idle_pct = 15;
      recv_idle_pct = 83;
      all_ops = '{OP_DIV, OP_REM, OP_DIVU, OP_REMU};
      // Sign combinations, the wrapping most-negative case, zero divisor,
      // and the field extremes, each under every operation.
      dir_dividend = '{-64'd7, 64'd7, MOST_NEG, 64'd0, ALL_ONES, MOST_POS};
      dir_divisor  = '{64'd2, -64'd2, ALL_ONES, 64'd0, 64'd1, MOST_NEG};
      hold_threshold = 24 + 2 * RANDOM_PER_RUN + 100;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < 4; k++) begin
         for (p = 0; p < 6; p++) begin
            item.opcode   = all_ops[k];
            item.dividend = dir_dividend[p];
            item.divisor  = dir_divisor[p];
            send_item(item);
         end
      end
      send_random(RANDOM_PER_RUN);

      send_idle_pct = 83;
      recv_idle_pct = 15;
      send_random(RANDOM_PER_RUN);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(RANDOM_PER_RUN);
      req_valid = 1'b0;

      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d results: div %0d, rem %0d, divu %0d, remu %0d",
               sb.checked, sb.op_count[OP_DIV], sb.op_count[OP_REM],
               sb.op_count[OP_DIVU], sb.op_count[OP_REMU]);
      $display("%0d zero-divisor results, one long output stall, %0d mismatches",
               sb.zero_divisor_seen, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/rd64_pkg.sv
rtl/core/rd64_prep.sv
rtl/core/rd64_cell.sv
rtl/core/rd64_post.sv
rtl/core/restoring_divider_64.sv
bench/testbench.sv
